>>> rtl/mmes_pkg.sv
`default_nettype none
package mmes_pkg;

  // Fixed-point format and slot count.
  localparam int FRAC       = 15;
  localparam int ONE        = 1 << FRAC;
  localparam int SLOT_COUNT = 8;
  localparam int NUM_DST    = 10;
  localparam int DW         = 28;

  // Saturation limits of the delta outputs.
  localparam logic signed [DW-1:0] LIM_CUTOFF = DW'(480 * ONE);
  localparam logic signed [DW-1:0] LIM_SHIFT  = DW'(4 * ONE);
  localparam logic signed [DW-1:0] LIM_DETUNE = DW'(800 * ONE);
  localparam logic signed [DW-1:0] LIM_WIDTH  = DW'((16 * ONE + 2) / 5);
  localparam logic [24:0]          LIM_LEVEL  = 25'(256 * ONE);

  typedef logic [25:0] slot_word_t;
  typedef logic [3:0]  cfg_index_t;

  // Source codes.
  localparam logic [3:0] SRC_LFO_ONE  = 4'd1;
  localparam logic [3:0] SRC_LFO_TWO  = 4'd2;
  localparam logic [3:0] SRC_AMP_ENV  = 4'd3;
  localparam logic [3:0] SRC_FILT_ENV = 4'd4;
  localparam logic [3:0] SRC_VELOCITY = 4'd5;
  localparam logic [3:0] SRC_KEY      = 4'd8;

  // Destination codes.
  localparam logic [3:0] DST_CUTOFF  = 4'd1;
  localparam logic [3:0] DST_RESO    = 4'd2;
  localparam logic [3:0] DST_DRIVE   = 4'd3;
  localparam logic [3:0] DST_DET1    = 4'd4;
  localparam logic [3:0] DST_DET2    = 4'd5;
  localparam logic [3:0] DST_LVL1    = 4'd6;
  localparam logic [3:0] DST_LVL2    = 4'd7;
  localparam logic [3:0] DST_PW1     = 4'd8;
  localparam logic [3:0] DST_PW2     = 4'd9;
  localparam logic [3:0] DST_MASTER  = 4'd10;

  // Curve codes.
  localparam logic [1:0] CRV_LIN  = 2'd0;
  localparam logic [1:0] CRV_SQR  = 2'd1;
  localparam logic [1:0] CRV_ROOT = 2'd2;
  localparam logic [1:0] CRV_TANH = 2'd3;

  typedef struct packed {
    logic signed [15:0] lfo_one;
    logic signed [15:0] lfo_two;
    logic [14:0]        amp_envelope;
    logic [14:0]        filter_envelope;
    logic [14:0]        note_velocity;
    logic signed [15:0] key_tracking;
  } frame_t;

  typedef struct packed {
    logic signed [24:0] cutoff_shift;
    logic signed [18:0] resonance_shift;
    logic signed [18:0] drive_shift;
    logic signed [25:0] osc_one_detune;
    logic signed [25:0] osc_two_detune;
    logic [23:0]        osc_one_level;
    logic [23:0]        osc_two_level;
    logic signed [17:0] osc_one_width_shift;
    logic signed [17:0] osc_two_width_shift;
    logic [23:0]        master_level;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/mmes_front.sv
`default_nettype none
module mmes_front
  import mmes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire slot_word_t cfg_wdata,
  input  wire logic       push,
  output logic            full,
  input  wire frame_t     frame_in,
  output slot_word_t      slots [SLOT_COUNT],
  output logic            frm_valid,
  output frame_t          frm_data,
  input  wire logic       frm_take
);

  slot_word_t slot_r [SLOT_COUNT];
  frame_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  // Slot registers; writes past the slot list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_r[i] <= '0;
    end else if (cfg_we && (32'(cfg_index) < SLOT_COUNT)) begin
      slot_r[cfg_index[$clog2(SLOT_COUNT)-1:0]] <= cfg_wdata;
    end
  end

  assign slots = slot_r;

  // Two-word frame queue toward the slot engine.
  assign full      = (cnt_r == 2'd2);
  assign frm_valid = (cnt_r != 2'd0);
  assign frm_data  = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = frm_take && frm_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= frame_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mmes_back.sv
`default_nettype none
module mmes_back
  import mmes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire slot_word_t slots [SLOT_COUNT],
  input  wire logic       frm_valid,
  input  wire frame_t     frm_data,
  output logic            frm_take,
  output logic            res_push,
  input  wire logic       res_full,
  output result_t         res_data
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_LOAD  = 12'b0000_0000_0010,
    ST_SQR   = 12'b0000_0000_0100,
    ST_ROOT  = 12'b0000_0000_1000,
    ST_T1    = 12'b0000_0001_0000,
    ST_T2    = 12'b0000_0010_0000,
    ST_T3    = 12'b0000_0100_0000,
    ST_T4    = 12'b0000_1000_0000,
    ST_DIV   = 12'b0001_0000_0000,
    ST_SCALE = 12'b0010_0000_0000,
    ST_APPLY = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_t;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [25:0] C945 = 26'(945 * ONE);
  localparam logic [16:0] ONE17 = 17'(ONE);

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r;
  logic [4:0]    it_r;
  logic          step_r;

  frame_t        frm_r;
  logic          neg_r;
  logic [15:0]   mag_r;
  logic signed [15:0] amt_r;
  logic [3:0]    dst_r;
  logic [16:0]   x_r;
  logic [17:0]   x2_r;
  logic [19:0]   x4_r;
  logic [26:0]   sum_r, den_r;
  logic [43:0]   num_r;
  logic [27:0]   drem_r;
  logic [16:0]   nlow_r, q_r;
  logic [31:0]   sqn_r;
  logic [19:0]   sqrem_r;
  logic [15:0]   root_r;
  logic [15:0]   shaped_r;
  logic          mneg_r;
  logic [16:0]   mmag_r;
  logic [40:0]   prod_r;
  logic signed [DW-1:0] dlt_r [NUM_DST];

  // Current slot fields.
  slot_word_t         slot_w;
  logic [3:0]         s_src, s_dst;
  logic [1:0]         s_crv;
  logic signed [15:0] s_amt;
  logic signed [16:0] src_val;
  logic               src_ok, skip, last;
  logic [16:0]        src_abs;

  assign slot_w = slots[idx_r];
  assign s_src  = slot_w[3:0];
  assign s_dst  = slot_w[7:4];
  assign s_crv  = slot_w[9:8];
  assign s_amt  = signed'(slot_w[25:10]);
  assign last   = (idx_r == IW'(SLOT_COUNT - 1));

  // Source selection.
  always_comb begin
    src_ok  = 1'b1;
    src_val = '0;
    unique case (s_src)
      SRC_LFO_ONE:  src_val = 17'(frm_r.lfo_one);
      SRC_LFO_TWO:  src_val = 17'(frm_r.lfo_two);
      SRC_AMP_ENV:  src_val = signed'({2'b00, frm_r.amp_envelope});
      SRC_FILT_ENV: src_val = signed'({2'b00, frm_r.filter_envelope});
      SRC_VELOCITY: src_val = signed'({2'b00, frm_r.note_velocity});
      SRC_KEY:      src_val = 17'(frm_r.key_tracking);
      default:      src_ok  = 1'b0;
    endcase
  end

  assign src_abs = src_val[16] ? 17'(-src_val) : 17'(src_val);
  assign skip    = (s_amt == 16'sd0) || !src_ok;

  // Square-root step: two radicand bits per cycle.
  logic [19:0] sq_try, sq_trial;
  assign sq_try   = {sqrem_r[17:0], sqn_r[31:30]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  // Divider step: one quotient bit per cycle.
  logic [27:0] dv_try;
  assign dv_try = {drem_r[26:0], nlow_r[16]};

  // Scaling by the amount.
  logic [16:0] amag;
  logic [32:0] pmul;
  logic [33:0] pround;
  assign amag   = amt_r[15] ? -17'(amt_r) : 17'(amt_r);
  assign pmul   = 33'(shaped_r) * 33'(amag);
  assign pround = 34'(pmul) + 34'(ONE / 2);

  function automatic logic [3:0] s_dix(input logic [3:0] d);
    s_dix = d - 4'd1;
  endfunction

  function automatic logic signed [DW-1:0] clamp_s(input logic signed [DW-1:0] v,
                                                    input logic signed [DW-1:0] lim);
    if (v > lim)       clamp_s = lim;
    else if (v < -lim) clamp_s = -lim;
    else               clamp_s = v;
  endfunction

  // Level factor and width numerator.
  logic [16:0] lvl_f;
  logic [18:0] w_num;
  logic [3:0]  dix;
  assign dix   = s_dix(dst_r);
  assign w_num = 19'({mmag_r, 2'b00}) + 19'd5;
  always_comb begin
    if (mneg_r) lvl_f = (mmag_r >= ONE17) ? 17'd0 : ONE17 - mmag_r;
    else        lvl_f = ONE17 + mmag_r;
  end

  // Contribution of one slot to its destination.
  logic [15:0]          w_q0;
  logic [19:0]          w_rem;
  logic [15:0]          w_q;
  logic [25:0]          lvl_p;
  logic [DW-1:0]        add_mag;
  logic signed [DW-1:0] dlt_new;
  logic                 dst_ok;
  always_comb begin
    w_q0    = prod_r[34:19];
    w_rem   = 20'(w_num) - 20'(w_q0) * 20'd10;
    w_q     = (w_rem >= 20'd10) ? w_q0 + 16'd1 : w_q0;
    lvl_p   = 26'((42'(prod_r) + 42'(ONE / 2)) >> FRAC);
    add_mag = '0;
    dst_ok  = 1'b1;
    dlt_new = dlt_r[dix];
    unique case (dst_r)
      DST_CUTOFF:          add_mag = DW'(mmag_r) * DW'(60);
      DST_RESO, DST_DRIVE: add_mag = DW'((18'(mmag_r) + 18'd1) >> 1);
      DST_DET1, DST_DET2:  add_mag = DW'(mmag_r) * DW'(100);
      DST_PW1, DST_PW2:    add_mag = DW'(w_q);
      DST_LVL1, DST_LVL2, DST_MASTER: add_mag = '0;
      default:             dst_ok  = 1'b0;
    endcase
    if (dst_r == DST_LVL1 || dst_r == DST_LVL2 || dst_r == DST_MASTER) begin
      dlt_new = (lvl_p > 26'(LIM_LEVEL)) ? DW'(LIM_LEVEL) : DW'(lvl_p);
    end else if (mneg_r) begin
      dlt_new = dlt_r[dix] - signed'(add_mag);
    end else begin
      dlt_new = dlt_r[dix] + signed'(add_mag);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    frm_take  = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (frm_valid) begin
          frm_take  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (skip) begin
          state_nxt = last ? ST_EMIT : ST_LOAD;
        end else begin
          unique case (s_crv)
            CRV_LIN:  state_nxt = ST_SCALE;
            CRV_SQR:  state_nxt = ST_SQR;
            CRV_ROOT: state_nxt = ST_ROOT;
            CRV_TANH: state_nxt = ST_T1;
          endcase
        end
      end
      ST_SQR:   state_nxt = ST_SCALE;
      ST_ROOT:  state_nxt = (it_r == 5'd15) ? ST_SCALE : ST_ROOT;
      ST_T1:    state_nxt = ST_T2;
      ST_T2:    state_nxt = ST_T3;
      ST_T3:    state_nxt = ST_T4;
      ST_T4:    state_nxt = step_r ? ST_DIV : ST_T4;
      ST_DIV:   state_nxt = (it_r == 5'd16) ? ST_SCALE : ST_DIV;
      ST_SCALE: state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (step_r) state_nxt = last ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      it_r    <= '0;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) idx_r <= '0;
      else if ((state_r == ST_LOAD && skip) || (state_r == ST_APPLY && step_r)) begin
        idx_r <= idx_r + IW'(1);
      end
      if (state_r == ST_ROOT || state_r == ST_DIV) it_r <= it_r + 5'd1;
      else                                          it_r <= '0;
      if (state_r == ST_T4 || state_r == ST_APPLY) step_r <= ~step_r;
      else                                         step_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        frm_r <= frm_data;
        // Deltas start at zero and level factors at one.
        for (int i = 0; i < NUM_DST; i++) begin
          dlt_r[i] <= (4'(i) == s_dix(DST_LVL1) || 4'(i) == s_dix(DST_LVL2) ||
                       4'(i) == s_dix(DST_MASTER)) ? DW'(ONE) : '0;
        end
      end
      ST_LOAD: begin
        neg_r    <= src_val[16];
        mag_r    <= src_abs[15:0];
        amt_r    <= s_amt;
        dst_r    <= s_dst;
        x_r      <= {src_abs[15:0], 1'b0};
        shaped_r <= src_abs[15:0];
        sqn_r    <= {1'b0, src_abs[15:0], 15'd0};
        sqrem_r  <= '0;
        root_r   <= '0;
      end
      ST_SQR: begin
        shaped_r <= 16'((33'(mag_r) * 33'(mag_r) + 33'(ONE / 2)) >> FRAC);
      end
      ST_ROOT: begin
        sqn_r <= {sqn_r[29:0], 2'b00};
        if (sq_try >= sq_trial) begin
          sqrem_r <= sq_try - sq_trial;
          root_r  <= {root_r[14:0], 1'b1};
        end else begin
          sqrem_r <= sq_try;
          root_r  <= {root_r[14:0], 1'b0};
        end
        if (it_r == 5'd15) shaped_r <= (sq_try >= sq_trial) ? {root_r[14:0], 1'b1}
                                                            : {root_r[14:0], 1'b0};
      end
      ST_T1: x2_r <= 18'((34'(x_r) * 34'(x_r)) >> FRAC);
      ST_T2: x4_r <= 20'((36'(x2_r) * 36'(x2_r)) >> FRAC);
      ST_T3: begin
        sum_r <= 27'(C945) + 27'(x2_r) * 27'd105 + 27'(x4_r);
        den_r <= 27'(C945) + 27'(x2_r) * 27'd420 + 27'(x4_r) * 27'd15;
      end
      ST_T4: begin
        if (!step_r) begin
          num_r <= 44'(x_r) * 44'(sum_r);
        end else begin
          drem_r <= 28'((45'(num_r) + 45'(den_r >> 1)) >> 17);
          nlow_r <= 17'(45'(num_r) + 45'(den_r >> 1));
          q_r    <= '0;
        end
      end
      ST_DIV: begin
        nlow_r <= {nlow_r[15:0], 1'b0};
        if (dv_try >= 28'(den_r)) begin
          drem_r <= dv_try - 28'(den_r);
          q_r    <= {q_r[15:0], 1'b1};
        end else begin
          drem_r <= dv_try;
          q_r    <= {q_r[15:0], 1'b0};
        end
        if (it_r == 5'd16) begin
          if (dv_try >= 28'(den_r)) begin
            shaped_r <= ({q_r[15:0], 1'b1} > ONE17) ? 16'(ONE) : q_r[15:0] << 1 | 16'd1;
          end else begin
            shaped_r <= ({q_r[15:0], 1'b0} > ONE17) ? 16'(ONE) : q_r[15:0] << 1;
          end
        end
      end
      ST_SCALE: begin
        mneg_r <= neg_r ^ amt_r[15];
        mmag_r <= 17'(pround >> FRAC);
      end
      ST_APPLY: begin
        if (!step_r) begin
          if (dst_r == DST_PW1 || dst_r == DST_PW2) begin
            prod_r <= 41'(w_num) * 41'd52428;
          end else begin
            prod_r <= 41'(dlt_r[dix][23:0]) * 41'(lvl_f);
          end
        end else if (dst_ok) begin
          dlt_r[dix] <= dlt_new;
        end
      end
      default: begin
      end
    endcase
  end

  // Final saturation of the shift, detune and width deltas.
  logic signed [DW-1:0] c_cut, c_res, c_drv, c_d1, c_d2, c_w1, c_w2;
  assign c_cut = clamp_s(dlt_r[s_dix(DST_CUTOFF)], LIM_CUTOFF);
  assign c_res = clamp_s(dlt_r[s_dix(DST_RESO)],   LIM_SHIFT);
  assign c_drv = clamp_s(dlt_r[s_dix(DST_DRIVE)],  LIM_SHIFT);
  assign c_d1  = clamp_s(dlt_r[s_dix(DST_DET1)],   LIM_DETUNE);
  assign c_d2  = clamp_s(dlt_r[s_dix(DST_DET2)],   LIM_DETUNE);
  assign c_w1  = clamp_s(dlt_r[s_dix(DST_PW1)],    LIM_WIDTH);
  assign c_w2  = clamp_s(dlt_r[s_dix(DST_PW2)],    LIM_WIDTH);

  always_comb begin
    res_data.cutoff_shift        = c_cut[24:0];
    res_data.resonance_shift     = c_res[18:0];
    res_data.drive_shift         = c_drv[18:0];
    res_data.osc_one_detune      = c_d1[25:0];
    res_data.osc_two_detune      = c_d2[25:0];
    res_data.osc_one_level       = dlt_r[s_dix(DST_LVL1)][23:0];
    res_data.osc_two_level       = dlt_r[s_dix(DST_LVL2)][23:0];
    res_data.osc_one_width_shift = c_w1[17:0];
    res_data.osc_two_width_shift = c_w2[17:0];
    res_data.master_level        = dlt_r[s_dix(DST_MASTER)][23:0];
  end

endmodule
`default_nettype wire

>>> rtl/mmes_outq.sv
`default_nettype none
module mmes_outq
  import mmes_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr,
  output logic         wr_full,
  input  wire result_t wdata,
  output logic         empty,
  input  wire logic    pop,
  output result_t      rdata
);

  result_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  // Two-word result queue.
  assign wr_full = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign wr_en   = wr && !wr_full;
  assign rd_en   = pop && !empty;
  assign cnt_nxt = cnt_r + 2'(wr_en) - 2'(rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/modulation_matrix_eight_slot.sv
`default_nettype none
// Channel   Handshake             Word
// input     push / full           six source values
// result    empty / pop           ten destination values
// config    cfg_we (no wait)      cfg_index, cfg_wdata
//
// A frame is loaded, then each active slot is shaped by its curve (linear,
// square, square root with radicand bits two per cycle, or tanh with one
// quotient bit per cycle), scaled and applied; inactive slots are skipped.
// Reset is synchronous, active low; it clears the slot registers and queues.
// Two-word queues on the input and result sides let either side stall alone.
module modulation_matrix_eight_slot
  import mmes_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [25:0]        cfg_wdata,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] in_lfo_one,
  input  wire logic signed [15:0] in_lfo_two,
  input  wire logic [14:0]        in_amp_envelope,
  input  wire logic [14:0]        in_filter_envelope,
  input  wire logic [14:0]        in_note_velocity,
  input  wire logic signed [15:0] in_key_tracking,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [24:0]      out_cutoff_shift,
  output logic signed [18:0]      out_resonance_shift,
  output logic signed [18:0]      out_drive_shift,
  output logic signed [25:0]      out_osc_one_detune,
  output logic signed [25:0]      out_osc_two_detune,
  output logic [23:0]             out_osc_one_level,
  output logic [23:0]             out_osc_two_level,
  output logic signed [17:0]      out_osc_one_width_shift,
  output logic signed [17:0]      out_osc_two_width_shift,
  output logic [23:0]             out_master_level
);

  frame_t     frame_in, frm_data;
  slot_word_t slots [SLOT_COUNT];
  logic       frm_valid, frm_take, res_push, res_full;
  result_t    res_data, res_head;

  assign frame_in.lfo_one         = in_lfo_one;
  assign frame_in.lfo_two         = in_lfo_two;
  assign frame_in.amp_envelope    = in_amp_envelope;
  assign frame_in.filter_envelope = in_filter_envelope;
  assign frame_in.note_velocity   = in_note_velocity;
  assign frame_in.key_tracking    = in_key_tracking;

  mmes_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .push, .full, .frame_in, .slots, .frm_valid, .frm_data, .frm_take
  );

  mmes_back u_back (
    .clk, .rst_n, .slots, .frm_valid, .frm_data, .frm_take,
    .res_push, .res_full, .res_data
  );

  mmes_outq u_outq (
    .clk, .rst_n, .wr(res_push), .wr_full(res_full), .wdata(res_data),
    .empty, .pop, .rdata(res_head)
  );

  assign out_cutoff_shift        = res_head.cutoff_shift;
  assign out_resonance_shift     = res_head.resonance_shift;
  assign out_drive_shift         = res_head.drive_shift;
  assign out_osc_one_detune      = res_head.osc_one_detune;
  assign out_osc_two_detune      = res_head.osc_two_detune;
  assign out_osc_one_level       = res_head.osc_one_level;
  assign out_osc_two_level       = res_head.osc_two_level;
  assign out_osc_one_width_shift = res_head.osc_one_width_shift;
  assign out_osc_two_width_shift = res_head.osc_two_width_shift;
  assign out_master_level        = res_head.master_level;

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mmes_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 240;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [3:0] cfg_index;
  logic [25:0] cfg_wdata;
  logic push;
  logic full;
  logic empty;
  logic pop;
  frame_t drv_frame;
  result_t got;
  logic typed_row;
  result_t typed_word;

  // Shadow of the slot registers, updated with every configuration write to a slot index.
  slot_word_t slot_shadow [8];
  result_t exp_q [$];
  int fails = 0;
  int cycles = 0;

  modulation_matrix_eight_slot dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .full(full),
    .in_lfo_one(drv_frame.lfo_one), .in_lfo_two(drv_frame.lfo_two),
    .in_amp_envelope(drv_frame.amp_envelope),
    .in_filter_envelope(drv_frame.filter_envelope),
    .in_note_velocity(drv_frame.note_velocity),
    .in_key_tracking(drv_frame.key_tracking),
    .empty(empty), .pop(pop),
    .out_cutoff_shift(got.cutoff_shift), .out_resonance_shift(got.resonance_shift),
    .out_drive_shift(got.drive_shift), .out_osc_one_detune(got.osc_one_detune),
    .out_osc_two_detune(got.osc_two_detune), .out_osc_one_level(got.osc_one_level),
    .out_osc_two_level(got.osc_two_level),
    .out_osc_one_width_shift(got.osc_one_width_shift),
    .out_osc_two_width_shift(got.osc_two_width_shift),
    .out_master_level(got.master_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, one result bit per pass.
  function automatic longint isqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Curve shaping on the magnitude, sign restored at the end.
  function automatic longint curve_value(longint v, logic [1:0] crv);
    longint one;
    longint mag;
    longint r;
    longint x;
    longint x2;
    longint x4;
    longint num;
    longint den;
    one = ONE;
    mag = (v < 0) ? -v : v;
    if (mag > one) mag = one;
    case (crv)
      CRV_SQR: r = (mag * mag + (one >> 1)) >> FRAC;
      CRV_ROOT: r = isqrt(mag << FRAC);
      CRV_TANH: begin
        x = 2 * mag;
        x2 = (x * x) >> FRAC;
        x4 = (x2 * x2) >> FRAC;
        num = x * (945 * one + 105 * x2 + x4);
        den = 945 * one + 420 * x2 + 15 * x4;
        r = (num + den / 2) / den;
      end
      default: r = mag;
    endcase
    if (r > one) r = one;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Destination frame that the current slot settings give for one source frame.
  function automatic result_t mod_frame(frame_t f);
    longint src [16];
    longint acc [10];
    longint one;
    longint amt;
    longint sh;
    longint p;
    longint mag;
    longint m;
    longint fac;
    longint lv;
    logic [3:0] s;
    logic [3:0] d;
    logic neg;
    result_t res;
    one = ONE;
    foreach (src[k]) src[k] = 0;
    src[SRC_LFO_ONE] = f.lfo_one;
    src[SRC_LFO_TWO] = f.lfo_two;
    src[SRC_AMP_ENV] = f.amp_envelope;
    src[SRC_FILT_ENV] = f.filter_envelope;
    src[SRC_VELOCITY] = f.note_velocity;
    src[SRC_KEY] = f.key_tracking;
    foreach (acc[k]) acc[k] = 0;
    acc[5] = one;
    acc[6] = one;
    acc[9] = one;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s = slot_shadow[i][3:0];
      d = slot_shadow[i][7:4];
      amt = longint'($signed(slot_shadow[i][25:10]));
      if (amt == 0) continue;
      if (!(s == SRC_LFO_ONE || s == SRC_LFO_TWO || s == SRC_AMP_ENV ||
            s == SRC_FILT_ENV || s == SRC_VELOCITY || s == SRC_KEY)) continue;
      sh = curve_value(src[s], slot_shadow[i][9:8]);
      p = sh * amt;
      neg = p < 0;
      mag = ((neg ? -p : p) + (one >> 1)) >> FRAC;
      m = neg ? -mag : mag;
      case (d)
        DST_CUTOFF: acc[0] += 60 * m;
        DST_RESO, DST_DRIVE: begin
          mag = (mag + 1) >> 1;
          acc[d - 1] += neg ? -mag : mag;
        end
        DST_DET1, DST_DET2: acc[d - 1] += 100 * m;
        DST_LVL1, DST_LVL2, DST_MASTER: begin
          fac = one + m;
          if (fac < 0) fac = 0;
          lv = (acc[d - 1] * fac + (one >> 1)) >> FRAC;
          if (lv > 256 * one) lv = 256 * one;
          acc[d - 1] = lv;
        end
        DST_PW1, DST_PW2: begin
          mag = (4 * mag + 5) / 10;
          acc[d - 1] += neg ? -mag : mag;
        end
        default: ;
      endcase
    end
    res.cutoff_shift = 25'(clip(acc[0], LIM_CUTOFF));
    res.resonance_shift = 19'(clip(acc[1], LIM_SHIFT));
    res.drive_shift = 19'(clip(acc[2], LIM_SHIFT));
    res.osc_one_detune = 26'(clip(acc[3], LIM_DETUNE));
    res.osc_two_detune = 26'(clip(acc[4], LIM_DETUNE));
    res.osc_one_level = 24'(acc[5]);
    res.osc_two_level = 24'(acc[6]);
    res.osc_one_width_shift = 18'(clip(acc[7], LIM_WIDTH));
    res.osc_two_width_shift = 18'(clip(acc[8], LIM_WIDTH));
    res.master_level = 24'(acc[9]);
    return res;
  endfunction

  // Input frames accepted at this edge queue up their expected results.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      if (typed_row) exp_q.push_back(typed_word);
      else exp_q.push_back(mod_frame(drv_frame));
    end
  end

  // Result words accepted at this edge are checked against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && pop && !empty) begin
      if (exp_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = exp_q.pop_front();
        if (got.cutoff_shift !== e.cutoff_shift) begin
          $error("cutoff_shift exp %0d got %0d", e.cutoff_shift, got.cutoff_shift); fails++;
        end
        if (got.resonance_shift !== e.resonance_shift) begin
          $error("resonance_shift exp %0d got %0d", e.resonance_shift, got.resonance_shift);
          fails++;
        end
        if (got.drive_shift !== e.drive_shift) begin
          $error("drive_shift exp %0d got %0d", e.drive_shift, got.drive_shift); fails++;
        end
        if (got.osc_one_detune !== e.osc_one_detune) begin
          $error("osc_one_detune exp %0d got %0d", e.osc_one_detune, got.osc_one_detune);
          fails++;
        end
        if (got.osc_two_detune !== e.osc_two_detune) begin
          $error("osc_two_detune exp %0d got %0d", e.osc_two_detune, got.osc_two_detune);
          fails++;
        end
        if (got.osc_one_level !== e.osc_one_level) begin
          $error("osc_one_level exp %0d got %0d", e.osc_one_level, got.osc_one_level); fails++;
        end
        if (got.osc_two_level !== e.osc_two_level) begin
          $error("osc_two_level exp %0d got %0d", e.osc_two_level, got.osc_two_level); fails++;
        end
        if (got.osc_one_width_shift !== e.osc_one_width_shift) begin
          $error("osc_one_width_shift exp %0d got %0d", e.osc_one_width_shift,
                 got.osc_one_width_shift);
          fails++;
        end
        if (got.osc_two_width_shift !== e.osc_two_width_shift) begin
          $error("osc_two_width_shift exp %0d got %0d", e.osc_two_width_shift,
                 got.osc_two_width_shift);
          fails++;
        end
        if (got.master_level !== e.master_level) begin
          $error("master_level exp %0d got %0d", e.master_level, got.master_level); fails++;
        end
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side stalls a random number of cycles before each word.
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Writes all eight slots plus one ignored index, one per cycle.
  task automatic program_slots(slot_word_t words [8]);
    for (int i = 0; i < 9; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i < 8) ? 4'(i) : 4'($urandom_range(8, 15));
      cfg_wdata <= (i < 8) ? words[i] : 26'($urandom);
      if (i < 8) slot_shadow[i] = words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(frame_t f, logic typed, result_t w);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    drv_frame <= f;
    typed_row <= typed;
    typed_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic slot_word_t mk_slot(logic [3:0] s, logic [3:0] d, logic [1:0] c,
                                         logic [15:0] a);
    return {a, c, d, s};
  endfunction

  function automatic logic [15:0] rand_word16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f.lfo_one = rand_word16();
    f.lfo_two = rand_word16();
    f.amp_envelope = 15'(rand_word16());
    f.filter_envelope = 15'(rand_word16());
    f.note_velocity = 15'(rand_word16());
    f.key_tracking = rand_word16();
    return f;
  endfunction

  function automatic slot_word_t rand_slot();
    logic [3:0] s;
    logic [3:0] d;
    logic [15:0] a;
    s = ($urandom_range(0, 4) == 0) ? 4'($urandom) :
        ($urandom_range(0, 5) == 0 ? SRC_KEY : 4'($urandom_range(1, 5)));
    d = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 10));
    a = rand_word16();
    return mk_slot(s, d, 2'($urandom), a);
  endfunction

  typedef struct {
    int phase;
    frame_t f;
    logic typed;
  } stim_row_t;

  initial begin
    slot_word_t dir_cfg [3][8];
    slot_word_t words [8];
    stim_row_t rows [$];
    frame_t fz;
    frame_t fmax;
    frame_t fmin;
    frame_t fmid;
    result_t idle_word;
    int cur_phase;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    push = 1'b0;
    drv_frame = '0;
    typed_row = 1'b0;
    typed_word = '0;
    foreach (slot_shadow[i]) slot_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fz = '0;
    fmax = {16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h7FFF};
    fmin = {16'h8000, 16'h8000, 15'h0000, 15'h0000, 15'h0000, 16'h8000};
    fmid = {16'h4000, 16'hC000, 15'h2000, 15'h6000, 15'h4000, 16'hE000};
    idle_word = '0;
    idle_word.osc_one_level = 24'(ONE);
    idle_word.osc_two_level = 24'(ONE);
    idle_word.master_level = 24'(ONE);

    // Phase one: eight of the ten destinations, each curve, extreme amounts.
    dir_cfg[1] = '{mk_slot(SRC_LFO_ONE, DST_CUTOFF, CRV_LIN, 16'h7FFF),
                   mk_slot(SRC_LFO_TWO, DST_RESO, CRV_SQR, 16'h8000),
                   mk_slot(SRC_AMP_ENV, DST_DRIVE, CRV_ROOT, 16'h7FFF),
                   mk_slot(SRC_FILT_ENV, DST_DET1, CRV_TANH, 16'h8000),
                   mk_slot(SRC_VELOCITY, DST_DET2, CRV_TANH, 16'h4000),
                   mk_slot(SRC_KEY, DST_LVL1, CRV_LIN, 16'h8000),
                   mk_slot(SRC_LFO_ONE, DST_LVL2, CRV_ROOT, 16'h7FFF),
                   mk_slot(SRC_KEY, DST_PW1, CRV_SQR, 16'hA000)};
    // Phase two: remaining destinations, stacked levels, and slots that do nothing
    // (unused source, zero amount, unused destinations).
    dir_cfg[2] = '{mk_slot(SRC_LFO_ONE, DST_PW2, CRV_TANH, 16'h7FFF),
                   mk_slot(SRC_LFO_TWO, DST_MASTER, CRV_LIN, 16'h7FFF),
                   mk_slot(SRC_KEY, DST_MASTER, CRV_TANH, 16'h7FFF),
                   mk_slot(4'd6, DST_CUTOFF, CRV_LIN, 16'h7FFF),
                   mk_slot(SRC_LFO_ONE, DST_CUTOFF, CRV_LIN, 16'h0000),
                   mk_slot(SRC_LFO_TWO, 4'd0, CRV_LIN, 16'h7FFF),
                   mk_slot(SRC_LFO_TWO, 4'd15, CRV_SQR, 16'h8000),
                   mk_slot(SRC_AMP_ENV, DST_MASTER, CRV_SQR, 16'h8000)};

    rows.push_back('{0, fz, 1'b1});
    rows.push_back('{0, fmax, 1'b1});
    rows.push_back('{0, fmin, 1'b1});
    for (int p = 1; p < 3; p++) begin
      rows.push_back('{p, fz, 1'b0});
      rows.push_back('{p, fmax, 1'b0});
      rows.push_back('{p, fmin, 1'b0});
      rows.push_back('{p, fmid, 1'b0});
      rows.push_back('{p, ~fmid, 1'b0});
    end

    // Directed table; a new phase reprograms the slots once the block is idle.
    cur_phase = 0;
    foreach (rows[r]) begin
      if (rows[r].phase != cur_phase) begin
        push <= 1'b0;
        settle();
        cur_phase = rows[r].phase;
        words = dir_cfg[cur_phase];
        program_slots(words);
      end
      send_frame(rows[r].f, rows[r].typed, idle_word);
    end

    // Random part: six settings of about a hundred frames each.
    for (int p = 0; p < 6; p++) begin
      push <= 1'b0;
      settle();
      foreach (words[i]) begin
        words[i] = rand_slot();
        if (p == 0) words[i][25:10] = 16'h7FFF;
        if (p == 1) words[i][25:10] = 16'h8000;
      end
      program_slots(words);
      for (int n = 0; n < 100; n++) send_frame(rand_frame(), 1'b0, idle_word);
    end
    push <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
